// ===== hdl/lmcs_pkg.sv =====
`default_nettype none

package lmcs_pkg;

  localparam int unsigned MATRIX_COLUMNS = 8;
  localparam int unsigned COL_W          = 3;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned DWELL_W        = 16;
  localparam int unsigned FRAME_W        = 8;
  localparam int unsigned LEN_W          = 9;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic              RST_SCROLL_MODE = 1'b1;
  localparam logic [DWELL_W-1:0] RST_DWELL_TICKS = 16'd2500;
  localparam logic [FRAME_W-1:0] RST_FRAMES      = 8'd50;
  localparam logic [LEN_W-1:0]   RST_MSG_LENGTH  = 9'd8;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL_MODE       = 2'd0,
    CFG_DWELL_TICKS       = 2'd1,
    CFG_FRAMES_PER_WINDOW = 2'd2,
    CFG_MESSAGE_LENGTH    = 2'd3
  } cfg_idx_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] widx;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rd_addr;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] win;
  } lmcs_item_t;

endpackage

`default_nettype wire

// ===== hdl/lmcs_front.sv =====
`default_nettype none

module lmcs_front import lmcs_pkg::*; #(
  parameter int unsigned MESSAGE_DEPTH = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       cfg_ready_o,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  operation_i,
  input  wire logic [BYTE_W-1:0]     write_index_i,
  input  wire logic [BYTE_W-1:0]     write_data_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output lmcs_item_t                 item_o
);

  localparam logic [LEN_W-1:0] DepthLen = LEN_W'(MESSAGE_DEPTH);
  localparam logic [LEN_W-1:0] ColsLen  = LEN_W'(MATRIX_COLUMNS);

  logic               scroll_q;
  logic [DWELL_W-1:0] dwell_ticks_q;
  logic [FRAME_W-1:0] frames_q;
  logic [LEN_W-1:0]   length_q;

  logic [DWELL_W-1:0] dwell_q, dwell_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [BYTE_W-1:0]  win_q, win_d;

  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   last_win;
  logic [LEN_W-1:0]   win_inc;
  logic [LEN_W-1:0]   rd_sum;
  logic [LEN_W-1:0]   rd_addr;
  logic [DWELL_W-1:0] dwell_inc;
  logic [FRAME_W-1:0] frame_inc;
  logic               scrolling;
  logic               is_tick;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i;
  assign is_tick     = (op_e'(operation_i) == OP_TICK);

  always_comb begin
    eff_len   = (length_q > DepthLen) ? DepthLen : length_q;
    scrolling = scroll_q && (eff_len > ColsLen);
    last_win  = eff_len - ColsLen;
    dwell_inc = dwell_q + DWELL_W'(1);
    frame_inc = frame_q + FRAME_W'(1);
    win_inc   = {1'b0, win_q} + LEN_W'(1);

    dwell_d = dwell_q;
    col_d   = col_q;
    frame_d = frame_q;
    win_d   = win_q;

    if (is_tick) begin
      dwell_d = dwell_inc;
      if (dwell_inc >= dwell_ticks_q) begin
        dwell_d = '0;
        col_d   = col_q + COL_W'(1);
        if (col_d == '0) begin
          frame_d = frame_inc;
          if (frame_inc >= frames_q) begin
            frame_d = '0;
            if (scrolling) begin
              win_d = (win_inc >= last_win) ? '0 : win_inc[BYTE_W-1:0];
            end
          end
        end
      end
    end

    if (!scrolling) begin
      win_d = '0;
    end

    // The window stays below the store depth, so one subtract wraps the sum.
    rd_sum  = {1'b0, win_d} + LEN_W'(col_d);
    rd_addr = (rd_sum >= DepthLen) ? (rd_sum - DepthLen) : rd_sum;

    item_o.op      = op_e'(operation_i);
    item_o.widx    = write_index_i;
    item_o.wdata   = write_data_i;
    item_o.rd_addr = rd_addr[BYTE_W-1:0];
    item_o.col     = col_d;
    item_o.win     = win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_q      <= RST_SCROLL_MODE;
      dwell_ticks_q <= RST_DWELL_TICKS;
      frames_q      <= RST_FRAMES;
      length_q      <= RST_MSG_LENGTH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCROLL_MODE:       scroll_q      <= cfg_data_i[0];
        CFG_DWELL_TICKS:       dwell_ticks_q <= cfg_data_i[DWELL_W-1:0];
        CFG_FRAMES_PER_WINDOW: frames_q      <= cfg_data_i[FRAME_W-1:0];
        CFG_MESSAGE_LENGTH:    length_q      <= cfg_data_i[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= '0;
      col_q   <= '0;
      frame_q <= '0;
      win_q   <= '0;
    end else if (push_o) begin
      dwell_q <= dwell_d;
      col_q   <= col_d;
      frame_q <= frame_d;
      win_q   <= win_d;
    end
  end

  a_dwell_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && is_tick) |=> $stable(dwell_q))
    else $error("dwell counter moved without an accepted tick");

  a_static_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !scrolling) |=> (win_q == '0))
    else $error("window moved while not scrolling");

  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (col_q == $past(col_q)) || (col_q == $past(col_q) + COL_W'(1)))
    else $error("column skipped");

endmodule

`default_nettype wire

// ===== hdl/lmcs_fifo.sv =====
`default_nettype none

module lmcs_fifo import lmcs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire lmcs_item_t  item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             not_empty_o,
  output lmcs_item_t       item_o
);

  lmcs_item_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o      = (count_q == 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign item_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lmcs_back.sv =====
`default_nettype none

module lmcs_back import lmcs_pkg::*; #(
  parameter int unsigned MESSAGE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               not_empty_i,
  input  wire lmcs_item_t         item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [BYTE_W-1:0]       row_bits_o,
  output logic [MATRIX_COLUMNS-1:0] column_enables_n_o,
  output logic [BYTE_W-1:0]       window_start_o
);

  localparam int unsigned AW = $clog2(MESSAGE_DEPTH);
  localparam logic [LEN_W-1:0] DepthLen = LEN_W'(MESSAGE_DEPTH);

  logic [BYTE_W-1:0]        mem [MESSAGE_DEPTH];
  logic [MESSAGE_DEPTH-1:0] vld_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic [BYTE_W-1:0] hit_data_q;
  logic [COL_W-1:0]  col_q;
  logic [BYTE_W-1:0] win_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign pop_o   = not_empty_i && (!out_valid_q || !out_stall_i);
  assign wr_addr = item_i.widx[AW-1:0];
  assign rd_addr = item_i.rd_addr[AW-1:0];
  assign wr_en   = pop_o && (item_i.op == OP_WRITE) && ({1'b0, item_i.widx} < DepthLen);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= item_i.wdata;
    end
    if (pop_o) begin
      rd_data_q  <= mem[rd_addr];
      rd_vld_q   <= vld_q[rd_addr];
      hit_q      <= wr_en && (wr_addr == rd_addr);
      hit_data_q <= item_i.wdata;
      col_q      <= item_i.col;
      win_q      <= item_i.win;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign row_bits_o         = hit_q ? hit_data_q : (rd_vld_q ? rd_data_q : '0);
  assign column_enables_n_o = ~(MATRIX_COLUMNS'(1) << col_q);
  assign window_start_o     = win_q;

endmodule

`default_nettype wire

// ===== hdl/led_matrix_column_scanner_core.sv =====
// LED matrix column scanner for an 8x8 display driven one column at a time.
// Input channel (in_valid_i / in_stall_o): each item is either a time tick or
// a write of one message byte into the on-chip store. Every accepted item
// produces exactly one result item on the output channel (out_valid_o /
// out_stall_i) carrying the row pattern, the active-low column enables and
// the current window start, all reflecting the state after that item.
// The configuration port (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Throughput: one item per cycle while the
// receiver does not stall, set by the counter update in the front end and a
// store that takes a write and a read each cycle.
// The front end updates the dwell, column, frame and window counters and
// computes the read address; a two-entry queue feeds the back end, which
// writes or reads the message store and holds the result register.
// Reset clears all counters, restores the register defaults and marks every
// store entry as unwritten, so the store reads as zero without a sweep.
// When the receiver stalls, the result register holds its item, the queue
// absorbs up to two more, and then in_stall_o rises until space returns.
`default_nettype none

module led_matrix_column_scanner_core import lmcs_pkg::*; #(
  parameter int unsigned MESSAGE_DEPTH = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   operation_i,
  input  wire logic [BYTE_W-1:0]      write_index_i,
  input  wire logic [BYTE_W-1:0]      write_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [BYTE_W-1:0]           row_bits_o,
  output logic [MATRIX_COLUMNS-1:0]   column_enables_n_o,
  output logic [BYTE_W-1:0]           window_start_o
);

  // Queue handshake between the front and back ends.
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;
  lmcs_item_t front_item;
  lmcs_item_t back_item;

  lmcs_front #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .write_index_i (write_index_i),
    .write_data_i  (write_data_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // Two entries let the front keep accepting while a result waits.
  lmcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .item_o      (back_item)
  );

  lmcs_back #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .not_empty_i        (not_empty),
    .item_i             (back_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .row_bits_o         (row_bits_o),
    .column_enables_n_o (column_enables_n_o),
    .window_start_o     (window_start_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_led_matrix_column_scanner_core.sv =====
`default_nettype none

// Self-checking bench for the LED matrix column scanner.
// A predictor written in this module keeps its own copy of the message store,
// the dwell, column, frame and window counters and the four registers. Every
// item accepted on the input channel is run through it, and the predicted
// result is queued. Every result accepted on the output channel is compared
// with the oldest queued prediction, field by field.
module tb_led_matrix_column_scanner_core import lmcs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MESSAGE_DEPTH  = 256;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Extra wait after the last predicted result has come out.
  localparam int unsigned DRAIN_PAUSE    = 6;

  // Block inputs start from known values at time zero.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_SCROLL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  operation_i   = OP_TICK;
  logic [BYTE_W-1:0]     write_index_i = '0;
  logic [BYTE_W-1:0]     write_data_i  = '0;
  logic                  out_stall_i   = 1'b0;

  logic                      cfg_ready_o;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [BYTE_W-1:0]         row_bits_o;
  logic [MATRIX_COLUMNS-1:0] column_enables_n_o;
  logic [BYTE_W-1:0]         window_start_o;

  led_matrix_column_scanner_core #(
    .MESSAGE_DEPTH(MESSAGE_DEPTH)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .write_index_i     (write_index_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .row_bits_o        (row_bits_o),
    .column_enables_n_o(column_enables_n_o),
    .window_start_o    (window_start_o)
  );

  always #5 clk_i = ~clk_i;

  // One displayed column as the block should present it.
  typedef struct {
    logic [BYTE_W-1:0]         row_bits;
    logic [MATRIX_COLUMNS-1:0] col_en_n;
    logic [BYTE_W-1:0]         win;
  } scan_result_t;

  scan_result_t expected_scans[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct  = 24;
  int unsigned recv_stall_pct = 63;

  // Predictor state: registers first, then the store and the counters.
  logic               cfg_mode;
  logic [DWELL_W-1:0] cfg_dwell;
  logic [FRAME_W-1:0] cfg_frames;
  logic [LEN_W-1:0]   cfg_len;
  logic [BYTE_W-1:0]  store_model [MESSAGE_DEPTH];
  logic [DWELL_W-1:0] dwell_cnt;
  logic [COL_W-1:0]   col_idx;
  logic [FRAME_W-1:0] frame_cnt;
  logic [BYTE_W-1:0]  win_off;

  // A length beyond the store counts as the whole store.
  function automatic int unsigned shown_length();
    return (cfg_len > MESSAGE_DEPTH) ? MESSAGE_DEPTH : int'(cfg_len);
  endfunction

  // The window only moves in scroll mode with more than one screen of message.
  function automatic bit is_scrolling();
    return (cfg_mode == 1'b1) && (shown_length() > MATRIX_COLUMNS);
  endfunction

  // Applies one item to the predictor and returns the column it shows.
  function automatic scan_result_t scan_one_item(logic op, logic [BYTE_W-1:0] idx,
                                                 logic [BYTE_W-1:0] data);
    scan_result_t      r;
    int unsigned       next_win;
    logic [BYTE_W-1:0] rd_addr;
    if (op == OP_WRITE) begin
      // Writes touch only the store; the scan counters stand still.
      store_model[idx] = data;
    end else begin
      dwell_cnt = dwell_cnt + 16'd1;
      // Compare with >= so that a dwell or frame setting of zero acts as one.
      if (dwell_cnt >= cfg_dwell) begin
        dwell_cnt = '0;
        col_idx   = col_idx + 3'd1;
        if (col_idx == '0) begin
          frame_cnt = frame_cnt + 8'd1;
          if (frame_cnt >= cfg_frames) begin
            frame_cnt = '0;
            if (is_scrolling()) begin
              // A window at or past the last one, left by a shorter length,
              // wraps to zero here just like the normal last window.
              next_win = win_off + 1;
              if (next_win >= shown_length() - MATRIX_COLUMNS) next_win = 0;
              win_off = next_win[BYTE_W-1:0];
            end
          end
        end
      end
    end
    if (!is_scrolling()) win_off = '0;
    // Eight-bit sum, so a read past the end of the store wraps around.
    rd_addr    = win_off + {5'b0, col_idx};
    r.row_bits = store_model[rd_addr];
    r.col_en_n = ~(8'b1 << col_idx);
    r.win      = win_off;
    return r;
  endfunction

  // Receiver: stalls at random, at the current stall percentage.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: tracks register writes, predicts each accepted item and checks
  // each accepted result. It also runs the watchdog over all three channels.
  always @(posedge clk_i) begin
    scan_result_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_idx_e'(cfg_index_i))
          CFG_SCROLL_MODE:       cfg_mode   = cfg_data_i[0];
          CFG_DWELL_TICKS:       cfg_dwell  = cfg_data_i[DWELL_W-1:0];
          CFG_FRAMES_PER_WINDOW: cfg_frames = cfg_data_i[FRAME_W-1:0];
          CFG_MESSAGE_LENGTH:    cfg_len    = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      // Check the output before queueing a new prediction, so that a result
      // can never be matched against an item accepted in the same cycle.
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_scans.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected scan result: row %02h col_n %02h win %0d",
                     row_bits_o, column_enables_n_o, window_start_o);
          mismatch_count++;
        end else begin
          want = expected_scans.pop_front();
          if (row_bits_o !== want.row_bits || column_enables_n_o !== want.col_en_n ||
              window_start_o !== want.win) begin
            if (mismatch_count < 10)
              $display("mismatch: exp row %02h col %02h win %0d, got row %02h col %02h win %0d",
                       want.row_bits, want.col_en_n, want.win,
                       row_bits_o, column_enables_n_o, window_start_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        expected_scans.push_back(scan_one_item(operation_i, write_index_i, write_data_i));
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("tb_led_matrix_column_scanner_core NOT OK");
          $finish;
        end
      end
    end
  end

  // Presents one item and returns at the clock edge that accepts it. Valid
  // stays high for back-to-back items and is only lowered for an idle gap.
  task automatic send_scan_item(logic op, logic [BYTE_W-1:0] idx, logic [BYTE_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    write_index_i <= idx;
    write_data_i  <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every predicted column has come out. The
  // first edge lets the monitor queue the item accepted just before.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_scans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_scan_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone idle.
  task automatic set_scan_config(logic [CFG_DATA_W-1:0] mode, logic [CFG_DATA_W-1:0] dwell,
                                 logic [CFG_DATA_W-1:0] frames, logic [CFG_DATA_W-1:0] len);
    wait_for_drain();
    write_scan_reg(CFG_SCROLL_MODE, mode);
    write_scan_reg(CFG_DWELL_TICKS, dwell);
    write_scan_reg(CFG_FRAMES_PER_WINDOW, frames);
    write_scan_reg(CFG_MESSAGE_LENGTH, len);
  endtask

  // Register defaults: the long default dwell keeps column zero on screen,
  // and a length of eight never scrolls. Writes hit both ends of the store.
  task automatic test_reset_defaults();
    send_scan_item(OP_WRITE, 8'd0, 8'hFF);
    send_scan_item(OP_WRITE, 8'd255, 8'h00);
    send_scan_item(OP_WRITE, 8'd1, 8'h5A);
    send_scan_item(OP_TICK, 8'hFF, 8'hFF);
  endtask

  // Static mode with zero dwell, zero frames and an empty message: every
  // tick moves to the next column and the window stays at zero.
  task automatic test_zero_counts();
    set_scan_config(16'd0, 16'd0, 16'd0, 16'd0);
    repeat (4) send_scan_item(OP_TICK, 8'h00, 8'h00);
  endtask

  // Ten bytes give windows zero and one; sixteen one-tick columns step the
  // window up once and then wrap it back to zero.
  task automatic test_scroll_wrap();
    set_scan_config(16'd1, 16'd1, 16'd1, 16'd10);
    repeat (16) send_scan_item(OP_TICK, 8'h00, 8'h00);
  endtask

  // Scroll a sixteen-byte message to window five, then shorten it to eleven
  // bytes so that the window sits past the last one and must wrap.
  task automatic test_stale_window();
    int unsigned i;
    set_scan_config(16'd1, 16'd1, 16'd1, 16'd16);
    for (i = 0; i < 16; i++) send_scan_item(OP_WRITE, i[BYTE_W-1:0], 8'($urandom));
    repeat (40) send_scan_item(OP_TICK, 8'($urandom), 8'($urandom));
    set_scan_config(16'd1, 16'd1, 16'd1, 16'd11);
    repeat (12) send_scan_item(OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  // Bursts of random items, each under a fresh random setting. Short dwell
  // and frame counts dominate so that the window moves often; the extremes
  // and over-long lengths turn up now and then. Bits above each register's
  // width carry junk that the block must drop.
  task automatic test_random_traffic(int unsigned item_goal, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned           sent;
    int unsigned           burst;
    int unsigned           len_val;
    logic [CFG_DATA_W-1:0] dwell_w;
    logic [BYTE_W-1:0]     frame_val;
    logic                  op;
    logic [BYTE_W-1:0]     idx;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(19))
        0:       dwell_w = 16'd0;
        1:       dwell_w = 16'hFFFF;
        2:       dwell_w = 16'($urandom);
        3, 4:    dwell_w = 16'($urandom_range(4, 12));
        default: dwell_w = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(9))
        0:       frame_val = 8'd0;
        1:       frame_val = 8'd255;
        default: frame_val = 8'($urandom_range(1, 2));
      endcase
      case ($urandom_range(15))
        0:       len_val = 0;
        1:       len_val = 8;
        2:       len_val = 9;
        3:       len_val = 256;
        4:       len_val = $urandom_range(257, 511);
        5:       len_val = $urandom_range(511);
        default: len_val = $urandom_range(10, 24);
      endcase
      set_scan_config({15'($urandom), ($urandom_range(9) < 7) ? 1'b1 : 1'b0}, dwell_w,
                      {8'($urandom), frame_val}, {7'($urandom), 9'(len_val)});
      burst = $urandom_range(16, 40);
      repeat (burst) begin
        op  = ($urandom_range(99) < 70) ? OP_TICK : OP_WRITE;
        idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(31));
        send_scan_item(op, idx, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    // Predictor starts from the reset state of the block.
    cfg_mode   = RST_SCROLL_MODE;
    cfg_dwell  = RST_DWELL_TICKS;
    cfg_frames = RST_FRAMES;
    cfg_len    = RST_MSG_LENGTH;
    foreach (store_model[i]) store_model[i] = '0;
    dwell_cnt  = '0;
    col_idx    = '0;
    frame_cnt  = '0;
    win_off    = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_counts();
    test_scroll_wrap();
    test_stale_window();
    test_random_traffic(90, 24, 63);
    test_random_traffic(90, 63, 24);
    test_random_traffic(90, 0, 0);

    wait_for_drain();
    if (mismatch_count == 0 && expected_scans.size() == 0)
      $display("tb_led_matrix_column_scanner_core OK");
    else
      $display("tb_led_matrix_column_scanner_core NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
